// ===== rtl/register_window_value_codec_defines.svh =====
// Assertion macros shared by the codec RTL.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef REGISTER_WINDOW_VALUE_CODEC_DEFINES_SVH
`define REGISTER_WINDOW_VALUE_CODEC_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define RWVC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("rwvc assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define RWVC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rwvc assertion failed");

`endif

// ===== rtl/rwvc_pkg.sv =====
// Types, constants and register indexes of the register window value codec.
// No dependencies.
package rwvc_pkg;

  localparam int unsigned MaxWords   = 4;
  localparam int unsigned CoreStages = 8;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 7;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WORD_COUNT = 3'd0,
    CFG_BYTE_BIG   = 3'd1,
    CFG_WORD_BIG   = 3'd2,
    CFG_VALUE_BITS = 3'd3,
    CFG_SIGNED     = 3'd4,
    CFG_BCD        = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    OP_DECODE = 1'b0,
    OP_ENCODE = 1'b1
  } op_e;

  typedef struct packed {
    logic [2:0] word_count;
    logic       byte_order_big;
    logic       word_order_big;
    logic [6:0] value_bits;
    logic       signed_mode;
    logic       bcd_mode;
  } cfg_t;

  typedef struct packed {
    logic        operation;
    logic [15:0] reg_word_0;
    logic [15:0] reg_word_1;
    logic [15:0] reg_word_2;
    logic [15:0] reg_word_3;
    logic [63:0] value_in;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] value_out;
    logic [15:0] reg_out_0;
    logic [15:0] reg_out_1;
    logic [15:0] reg_out_2;
    logic [15:0] reg_out_3;
  } out_beat_t;

  // Item state carried down the pipeline.
  typedef struct packed {
    op_e         op;
    logic        neg;
    logic [63:0] plain;
    logic [63:0] work;
    logic [63:0] acc;
  } stage_t;

  // Effective window size, 1..4, and its low two bits minus one.
  function automatic logic [1:0] last_word(logic [2:0] wc);
    logic [1:0] r;
    if (wc == 3'd0) r = 2'd0;
    else if (wc > 3'(MaxWords)) r = 2'(MaxWords - 1);
    else r = wc[1:0] - 2'd1;
    return r;
  endfunction

endpackage

// ===== rtl/register_window_value_codec.sv =====
// Throughput: one beat per cycle; the front stage, eight BCD stages and the
// output register all advance together and hold as a whole when the output stalls.
// Reset clears all valid bits and loads the configuration reset values:
// one word, big-endian bytes and words, 16 bits, unsigned, binary.
// Depends on rwvc_pkg, its stage modules and the defines header.
`include "register_window_value_codec_defines.svh"
module register_window_value_codec (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [6:0]           cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  rwvc_pkg::in_beat_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output rwvc_pkg::out_beat_t  out_data_o
);
  import rwvc_pkg::*;

  cfg_t      cfg_q;
  logic      adv;
  stage_t    front_d;
  stage_t    st_q [CoreStages+1];
  stage_t    st_d [CoreStages];
  logic      vld_q [CoreStages+1];
  logic      out_vld_q;
  out_beat_t out_d;
  out_beat_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.word_count     <= 3'd1;
      cfg_q.byte_order_big <= 1'b1;
      cfg_q.word_order_big <= 1'b1;
      cfg_q.value_bits     <= 7'd16;
      cfg_q.signed_mode    <= 1'b0;
      cfg_q.bcd_mode       <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_WORD_COUNT: cfg_q.word_count     <= cfg_data_i[2:0];
        CFG_BYTE_BIG:   cfg_q.byte_order_big <= cfg_data_i[0];
        CFG_WORD_BIG:   cfg_q.word_order_big <= cfg_data_i[0];
        CFG_VALUE_BITS: cfg_q.value_bits     <= cfg_data_i;
        CFG_SIGNED:     cfg_q.signed_mode    <= cfg_data_i[0];
        CFG_BCD:        cfg_q.bcd_mode       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign adv        = !out_vld_q || out_ready_i;
  assign in_ready_o = adv;

  rwvc_front u_front (.cfg_i(cfg_q), .in_i(in_data_i), .st_o(front_d));

  for (genvar g = 0; g < CoreStages; g++) begin : g_core
    rwvc_core_stage u_stage (.st_i(st_q[g]), .st_o(st_d[g]));
  end

  rwvc_back u_back (.cfg_i(cfg_q), .st_i(st_q[CoreStages]), .out_o(out_d));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= CoreStages; i++) vld_q[i] <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= in_valid_i;
      for (int i = 0; i < CoreStages; i++) vld_q[i+1] <= vld_q[i];
      out_vld_q <= vld_q[CoreStages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_q[0] <= front_d;
      for (int i = 0; i < CoreStages; i++) st_q[i+1] <= st_d[i];
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  `RWVC_ASSERT(a_ready_follows_out, in_ready_o == (!out_valid_o || out_ready_i))
  `RWVC_ASSERT(a_decode_no_regs, !(out_valid_o && out_data_o.value_out != 64'd0 &&
    (out_data_o.reg_out_0 != 16'd0 || out_data_o.reg_out_1 != 16'd0 ||
     out_data_o.reg_out_2 != 16'd0 || out_data_o.reg_out_3 != 16'd0)))
  `RWVC_ASSERT_NEXT(a_stall_holds_front, !adv, vld_q[0] == $past(vld_q[0]))
  `RWVC_ASSERT_NEXT(a_last_stage_moves, adv && vld_q[CoreStages], out_valid_o)
endmodule

// ===== rtl/rwvc_front.sv =====
// Front stage: assembles the window into a byte stream, masks, sign-extends.
// Depends on rwvc_pkg.
module rwvc_front (
  input  rwvc_pkg::cfg_t     cfg_i,
  input  rwvc_pkg::in_beat_t in_i,
  output rwvc_pkg::stage_t   st_o
);
  import rwvc_pkg::*;

  logic [1:0]  nm1;
  logic [6:0]  bits;
  logic [5:0]  sbit;
  logic [63:0] mask;
  logic [63:0] raw;
  logic [63:0] masked_in;
  logic [15:0] regs [MaxWords];
  logic [15:0] sw;
  logic [1:0]  sidx;

  always_comb begin
    nm1 = last_word(cfg_i.word_count);
    if (cfg_i.value_bits == 7'd0) bits = 7'd1;
    else if (cfg_i.value_bits > 7'd64) bits = 7'd64;
    else bits = cfg_i.value_bits;
    sbit = 6'(bits - 7'd1);
    mask = (bits == 7'd64) ? '1 : ((64'd1 << bits) - 64'd1);
    regs[0] = in_i.reg_word_0;
    regs[1] = in_i.reg_word_1;
    regs[2] = in_i.reg_word_2;
    regs[3] = in_i.reg_word_3;
    raw = '0;
    for (int r = 0; r < MaxWords; r++) begin
      sidx = cfg_i.word_order_big ? (nm1 - 2'(r)) : 2'(r);
      sw = cfg_i.byte_order_big ? regs[r] : {regs[r][7:0], regs[r][15:8]};
      if (2'(r) <= nm1) raw = raw | (64'(sw) << {sidx, 4'b0000});
    end
    raw = raw & mask;
    masked_in = in_i.value_in & mask;

    st_o.op = op_e'(in_i.operation);
    if (in_i.operation == OP_DECODE) begin
      st_o.neg = 1'b0;
      st_o.work = raw;
      if (cfg_i.signed_mode && bits != 7'd64 && raw[sbit]) st_o.plain = raw | ~mask;
      else st_o.plain = raw;
    end else begin
      st_o.neg = masked_in[63];
      st_o.work = masked_in;
      st_o.plain = masked_in;
    end
    st_o.acc = '0;
  end
endmodule

// ===== rtl/rwvc_core_stage.sv =====
// One BCD stage: eight double-dabble steps for encode or one byte of
// base-100 accumulation for decode. Depends on rwvc_pkg.
module rwvc_core_stage (
  input  rwvc_pkg::stage_t st_i,
  output rwvc_pkg::stage_t st_o
);
  import rwvc_pkg::*;

  logic [63:0] dig;
  logic [63:0] wk;
  logic [7:0]  byte_v;
  logic [63:0] dec_acc;

  always_comb begin
    dig = st_i.acc;
    wk = st_i.work;
    // Digits above the sixteenth fall off the top, which keeps the value mod 10^16.
    for (int j = 0; j < 8; j++) begin
      for (int k = 0; k < 16; k++) begin
        if (dig[4*k +: 4] >= 4'd5) dig[4*k +: 4] = dig[4*k +: 4] + 4'd3;
      end
      dig = {dig[62:0], wk[63]};
      wk = {wk[62:0], 1'b0};
    end
    byte_v = st_i.work[63:56];
    dec_acc = (st_i.acc << 6) + (st_i.acc << 5) + (st_i.acc << 2)
            + 64'({byte_v[7:4], 3'b000}) + 64'({byte_v[7:4], 1'b0})
            + 64'(byte_v[3:0]);
    st_o = st_i;
    if (st_i.op == OP_ENCODE) begin
      st_o.acc = dig;
      st_o.work = wk;
    end else begin
      st_o.acc = dec_acc;
      st_o.work = {st_i.work[55:0], 8'h00};
    end
  end
endmodule

// ===== rtl/rwvc_back.sv =====
// Back stage: picks the result and splits an encoded value into registers.
// Depends on rwvc_pkg.
module rwvc_back (
  input  rwvc_pkg::cfg_t      cfg_i,
  input  rwvc_pkg::stage_t    st_i,
  output rwvc_pkg::out_beat_t out_o
);
  import rwvc_pkg::*;

  logic [1:0]  nm1;
  logic [1:0]  sidx;
  logic [63:0] enc;
  logic [15:0] sw;
  logic [15:0] regs [MaxWords];

  always_comb begin
    nm1 = last_word(cfg_i.word_count);
    if (!cfg_i.bcd_mode) enc = st_i.plain;
    else if (st_i.neg) enc = '0;
    else enc = st_i.acc;
    for (int r = 0; r < MaxWords; r++) begin
      sidx = cfg_i.word_order_big ? (nm1 - 2'(r)) : 2'(r);
      sw = 16'(enc >> {sidx, 4'b0000});
      if (!cfg_i.byte_order_big) sw = {sw[7:0], sw[15:8]};
      regs[r] = (2'(r) <= nm1 && st_i.op == OP_ENCODE) ? sw : 16'h0000;
    end
    if (st_i.op == OP_ENCODE) out_o.value_out = '0;
    else out_o.value_out = cfg_i.bcd_mode ? st_i.acc : st_i.plain;
    out_o.reg_out_0 = regs[0];
    out_o.reg_out_1 = regs[1];
    out_o.reg_out_2 = regs[2];
    out_o.reg_out_3 = regs[3];
  end
endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the register window value codec.
// Random and directed windows across configurations, checked against an inline predictor.
// Depends on rwvc_pkg and register_window_value_codec.
`timescale 1ns / 100ps
module testbench;
  import rwvc_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [6:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_beat_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_beat_t out_data_o;

  register_window_value_codec i_dut (.*);

  always #10 clk_i = ~clk_i;

  in_beat_t pending_beats[$];
  out_beat_t expected_beats[$];
  int errors = 0;
  bit quiet = 1'b0;       // no idling on either side
  int hold_off = 0;       // receiver hold-off cycles requested

  logic [2:0] word_count_q;
  logic byte_big_q, word_big_q, signed_q, bcd_q;
  logic [6:0] value_bits_q;

  function automatic int unsigned stream_reg(int unsigned pos, int unsigned n);
    return word_big_q ? pos / 2 : n - 1 - pos / 2;
  endfunction

  function automatic bit stream_high(int unsigned pos);
    return byte_big_q ? (pos % 2 == 0) : (pos % 2 == 1);
  endfunction

  function automatic out_beat_t predict_window(in_beat_t b);
    int unsigned n, bits, r;
    logic [63:0] mask, raw, val;
    logic [15:0] regs[4];
    logic [7:0] by;
    out_beat_t o;
    n = (word_count_q == 0) ? 1 : (word_count_q > 4) ? 4 : word_count_q;
    bits = (value_bits_q == 0) ? 1 : (value_bits_q > 64) ? 64 : value_bits_q;
    mask = (bits >= 64) ? '1 : ((64'd1 << bits) - 64'd1);
    o = '0;
    if (b.operation == OP_DECODE) begin
      regs[0] = b.reg_word_0; regs[1] = b.reg_word_1;
      regs[2] = b.reg_word_2; regs[3] = b.reg_word_3;
      raw = '0;
      for (int unsigned p = 0; p < n * 2; p++) begin
        r = stream_reg(p, n) & 3;
        by = stream_high(p) ? regs[r][15:8] : regs[r][7:0];
        raw = {raw[55:0], by};
      end
      raw &= mask;
      if (bcd_q) begin
        val = '0;
        for (int k = n * 2 - 1; k >= 0; k--) begin
          by = raw[8*k +: 8];
          val = val * 100 + by[7:4] * 10 + by[3:0];
        end
      end else if (signed_q && bits < 64 && raw[bits-1]) begin
        val = raw | ~mask;
      end else begin
        val = raw;
      end
      o.value_out = val;
    end else begin
      raw = b.value_in & mask;
      if (bcd_q) begin
        val = raw;
        raw = '0;
        if (!val[63]) begin
          for (int unsigned s = 0; s < 64 && val != 0; s += 4) begin
            raw |= (val % 10) << s;
            val /= 10;
          end
        end
      end
      regs = '{default: '0};
      for (int p = n * 2 - 1; p >= 0; p--) begin
        r = stream_reg(p, n) & 3;
        if (stream_high(p)) regs[r][15:8] = raw[7:0];
        else regs[r][7:0] = raw[7:0];
        raw >>= 8;
      end
      o.reg_out_0 = regs[0]; o.reg_out_1 = regs[1];
      o.reg_out_2 = regs[2]; o.reg_out_3 = regs[3];
    end
    return o;
  endfunction

  // Driver: one beat per handshake, valid held until accepted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_beats.push_back(predict_window(in_data_i));
        void'(pending_beats.pop_front());
      end
      if (in_valid_i && !in_ready_o) begin
      end else if (pending_beats.size() > 0 && (quiet || $urandom_range(99) >= 8)
                   && !(in_valid_i && in_ready_o && pending_beats.size() == 0)) begin
        in_valid_i <= 1'b1;
        in_data_i <= pending_beats[0];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor and receiver stall control.
  always @(posedge clk_i) begin
    out_beat_t exp_b;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_beats.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          exp_b = expected_beats.pop_front();
          if (out_data_o.value_out !== exp_b.value_out) begin
            $error("value_out exp %h got %h", exp_b.value_out, out_data_o.value_out);
            errors++;
          end
          if (out_data_o.reg_out_0 !== exp_b.reg_out_0) begin
            $error("reg_out_0 exp %h got %h", exp_b.reg_out_0, out_data_o.reg_out_0);
            errors++;
          end
          if (out_data_o.reg_out_1 !== exp_b.reg_out_1) begin
            $error("reg_out_1 exp %h got %h", exp_b.reg_out_1, out_data_o.reg_out_1);
            errors++;
          end
          if (out_data_o.reg_out_2 !== exp_b.reg_out_2) begin
            $error("reg_out_2 exp %h got %h", exp_b.reg_out_2, out_data_o.reg_out_2);
            errors++;
          end
          if (out_data_o.reg_out_3 !== exp_b.reg_out_3) begin
            $error("reg_out_3 exp %h got %h", exp_b.reg_out_3, out_data_o.reg_out_3);
            errors++;
          end
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= quiet || $urandom_range(99) >= 8;
      end
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [6:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_WORD_COUNT: word_count_q = data[2:0];
      CFG_BYTE_BIG:   byte_big_q = data[0];
      CFG_WORD_BIG:   word_big_q = data[0];
      CFG_VALUE_BITS: value_bits_q = data;
      CFG_SIGNED:     signed_q = data[0];
      CFG_BCD:        bcd_q = data[0];
      default: ;
    endcase
  endtask

  task automatic drain_all();
    while (pending_beats.size() > 0 || in_valid_i || expected_beats.size() > 0)
      @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  function automatic in_beat_t random_window();
    in_beat_t b;
    b.operation = 1'($urandom_range(1));
    b.reg_word_0 = 16'($urandom); b.reg_word_1 = 16'($urandom);
    b.reg_word_2 = 16'($urandom); b.reg_word_3 = 16'($urandom);
    b.value_in = {$urandom, $urandom};
    case ($urandom_range(5))
      0: b.value_in = b.value_in >> $urandom_range(63);
      1: b.value_in = {$urandom_range(9), $urandom_range(9999)};
      2: b.value_in = 64'd9999999999999999 + $urandom_range(20) - 10;
      default: ;
    endcase
    if ($urandom_range(3) == 0) begin
      // Packed BCD-looking window for decode.
      b.reg_word_0 = {4'($urandom_range(9)), 4'($urandom_range(9)),
                      4'($urandom_range(9)), 4'($urandom_range(9))};
    end
    return b;
  endfunction

  initial begin
    in_beat_t b;
    word_count_q = 3'd1; byte_big_q = 1'b1; word_big_q = 1'b1;
    value_bits_q = 7'd16; signed_q = 1'b0; bcd_q = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed extremes at reset settings, then at wide signed, zero width and count, and oversized BCD settings.
    b = '0; pending_beats.push_back(b);
    b = '1; b.operation = OP_DECODE; pending_beats.push_back(b);
    b = '1; b.operation = OP_ENCODE; pending_beats.push_back(b);
    drain_all();
    write_reg(CFG_WORD_COUNT, 7'd4);
    write_reg(CFG_VALUE_BITS, 7'd64);
    write_reg(CFG_SIGNED, 7'd1);
    b = '1; b.operation = OP_DECODE; pending_beats.push_back(b);
    b = '0; b.reg_word_0 = 16'h8000; pending_beats.push_back(b);
    b = '0; b.operation = OP_ENCODE; b.value_in = 64'h0123_4567_89ab_cdef;
    pending_beats.push_back(b);
    drain_all();
    write_reg(CFG_VALUE_BITS, 7'd0);
    write_reg(CFG_WORD_COUNT, 7'd0);
    b = '1; b.operation = OP_DECODE; pending_beats.push_back(b);
    b = '1; b.operation = OP_ENCODE; pending_beats.push_back(b);
    drain_all();
    write_reg(CFG_VALUE_BITS, 7'd127);
    write_reg(CFG_WORD_COUNT, 7'd7);
    write_reg(CFG_BCD, 7'd1);
    b = '1; b.operation = OP_DECODE; pending_beats.push_back(b);
    b = '0; b.reg_word_0 = 16'h9999; b.reg_word_3 = 16'h1234; pending_beats.push_back(b);
    b = '0; b.operation = OP_ENCODE; b.value_in = 64'h8000_0000_0000_0000;
    pending_beats.push_back(b);
    b.value_in = 64'd12345678901234567890 - 64'd1; pending_beats.push_back(b);
    b.value_in = 64'd9999999999999999; pending_beats.push_back(b);
    drain_all();

    // Random phases, each under a fresh configuration.
    for (int ph = 0; ph < 30; ph++) begin
      write_reg(CFG_WORD_COUNT, 7'($urandom_range(7)));
      write_reg(CFG_BYTE_BIG, 7'($urandom_range(1)));
      write_reg(CFG_WORD_BIG, 7'($urandom_range(1)));
      write_reg(CFG_VALUE_BITS, ($urandom_range(4) == 0) ? 7'($urandom_range(127))
                                : 7'($urandom_range(64, 1)));
      write_reg(CFG_SIGNED, 7'($urandom_range(1)));
      write_reg(CFG_BCD, 7'($urandom_range(1)));
      quiet = (ph == 5);
      if (ph == 10) hold_off = 60;
      for (int i = 0; i < 64; i++) pending_beats.push_back(random_window());
      // Sender pauses until every result is back.
      drain_all();
    end

    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #4ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/rwvc_pkg.sv
rtl/rwvc_front.sv
rtl/rwvc_core_stage.sv
rtl/rwvc_back.sv
rtl/register_window_value_codec.sv
sim/testbench.sv
